### rtl/level_alarm_hysteresis_ratelimit_defines.svh
// Assertion macros shared by the checker.
`ifndef LEVEL_ALARM_HYSTERESIS_RATELIMIT_DEFINES_SVH
`define LEVEL_ALARM_HYSTERESIS_RATELIMIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define LAHR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define LAHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lahr_pkg.sv
`timescale 1ns / 1ps

package lahr_pkg;

	typedef logic [9:0]  level_t;
	typedef logic [31:0] msec_t;
	typedef logic [1:0]  kind_t;
	typedef logic [2:0]  reg_index_t;

	// Alarm kind codes as reported on the result
	localparam kind_t KIND_LOW    = 2'd0;
	localparam kind_t KIND_CRIT   = 2'd1;
	localparam kind_t KIND_HIGH   = 2'd2;
	localparam kind_t KIND_SENSOR = 2'd3;

	// Bit positions of a lane's fire mask, in emission order
	localparam int unsigned EMIT_CRIT   = 0;
	localparam int unsigned EMIT_LOW    = 1;
	localparam int unsigned EMIT_HIGH   = 2;
	localparam int unsigned EMIT_SENSOR = 3;
	localparam int unsigned EMIT_W      = 4;

	// Configuration register indexes
	localparam reg_index_t REG_CRIT_LOW     = 3'd0;
	localparam reg_index_t REG_LOW          = 3'd1;
	localparam reg_index_t REG_HIGH         = 3'd2;
	localparam reg_index_t REG_HYSTERESIS   = 3'd3;
	localparam reg_index_t REG_MIN_INTERVAL = 3'd4;

	// Reset values of the configuration
	localparam level_t RST_CRIT_LOW     = 10'd100;
	localparam level_t RST_LOW          = 10'd200;
	localparam level_t RST_HIGH         = 10'd900;
	localparam level_t RST_HYSTERESIS   = 10'd50;
	localparam msec_t  RST_MIN_INTERVAL = 32'd300000;

	typedef struct packed {
		level_t level_a;
		level_t level_b;
		logic   sensor_ok_a;
		logic   sensor_ok_b;
		msec_t  now_ms;
	} sample_t;

	typedef struct packed {
		logic   channel;
		kind_t  alarm_kind;
		level_t level;
		logic   last;
	} alarm_t;

	typedef struct packed {
		level_t critical_low_level;
		level_t low_level;
		level_t high_level;
		level_t hysteresis_band;
		msec_t  min_interval_ms;
	} cfg_t;

endpackage

### rtl/lahr_lane.sv
`timescale 1ns / 1ps

// One channel: latch bits, per-kind time stamps and the alarm decisions
module lahr_lane import lahr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  level_t            level,
	input  logic              sensor_ok,
	input  msec_t             now_ms,
	input  cfg_t              cfg,
	output logic [EMIT_W-1:0] fire
);

	logic [2:0] flags_q;      // bit0 low, bit1 critical, bit2 high
	logic [2:0] flags_next;
	msec_t      stamp_q [4];  // indexed by kind code
	msec_t      elapsed [4];
	logic [3:0] passed;

	logic              crit_zone, crit_rearm;
	logic              low_zone, low_rearm;
	logic              high_zone, high_rearm;
	logic signed [11:0] high_limit;

	// Rate limit: wrapping elapsed time per kind
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			elapsed[k] = now_ms - stamp_q[k];
			passed[k]  = (elapsed[k] >= cfg.min_interval_ms);
		end
	end

	// Zone and re-arm compares
	always_comb begin
		crit_zone  = (level <= cfg.critical_low_level);
		crit_rearm = ({1'b0, level} > ({1'b0, cfg.critical_low_level}
			+ {1'b0, cfg.hysteresis_band}));
		low_zone   = (level <= cfg.low_level) && (level > cfg.critical_low_level);
		low_rearm  = ({1'b0, level} > ({1'b0, cfg.low_level} + {1'b0, cfg.hysteresis_band}));
		high_zone  = (level >= cfg.high_level);
		high_limit = $signed({2'b00, cfg.high_level}) - $signed({2'b00, cfg.hysteresis_band});
		high_rearm = ($signed({2'b00, level}) < high_limit);
	end

	// Alarm decisions
	always_comb begin
		fire              = '0;
		fire[EMIT_SENSOR] = !sensor_ok && passed[KIND_SENSOR];
		fire[EMIT_CRIT]   = sensor_ok && crit_zone && !flags_q[1] && passed[KIND_CRIT];
		fire[EMIT_LOW]    = sensor_ok && low_zone && !flags_q[0] && passed[KIND_LOW];
		fire[EMIT_HIGH]   = sensor_ok && high_zone && !flags_q[2] && passed[KIND_HIGH];
	end

	// Latch update; a failed sensor leaves the latches alone
	always_comb begin
		flags_next = flags_q;
		if (sensor_ok) begin
			if (crit_zone) begin
				flags_next[1] = flags_q[1] | fire[EMIT_CRIT];
			end else if (crit_rearm) begin
				flags_next[1] = 1'b0;
			end
			if (low_zone) begin
				flags_next[0] = flags_q[0] | fire[EMIT_LOW];
			end else if (low_rearm) begin
				flags_next[0] = 1'b0;
			end
			if (high_zone) begin
				flags_next[2] = flags_q[2] | fire[EMIT_HIGH];
			end else if (high_rearm) begin
				flags_next[2] = 1'b0;
			end
		end
	end

	// State commit when the item moves on to the merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			for (int k = 0; k < 4; k++) begin
				stamp_q[k] <= '0;
			end
		end else if (commit) begin
			flags_q <= flags_next;
			if (fire[EMIT_LOW]) begin
				stamp_q[KIND_LOW] <= now_ms;
			end
			if (fire[EMIT_CRIT]) begin
				stamp_q[KIND_CRIT] <= now_ms;
			end
			if (fire[EMIT_HIGH]) begin
				stamp_q[KIND_HIGH] <= now_ms;
			end
			if (fire[EMIT_SENSOR]) begin
				stamp_q[KIND_SENSOR] <= now_ms;
			end
		end
	end

endmodule

### rtl/lahr_merge.sv
`timescale 1ns / 1ps

// Merges both lanes' fire masks and sends one result per cycle while alarm_stall is low
module lahr_merge import lahr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [EMIT_W-1:0] fire_a,
	input  logic [EMIT_W-1:0] fire_b,
	input  level_t            level_a,
	input  level_t            level_b,
	output logic              take,
	output logic              alarm_valid,
	input  logic              alarm_stall,
	output alarm_t            alarm
);

	localparam int unsigned PEND_W = 2 * EMIT_W;

	logic [PEND_W-1:0] pend_q, pick, pend_rest, pend_after;
	level_t            lvl_a_q, lvl_b_q;
	logic              out_valid_q;
	alarm_t            out_q;
	logic              pop;
	logic [2:0]        idx;
	alarm_t            nxt;

	// Lowest pending result goes next
	always_comb begin
		pick       = pend_q & (~pend_q + PEND_W'(1));
		pend_rest  = pend_q & ~pick;
		pop        = (pend_q != '0) && (!out_valid_q || !alarm_stall);
		pend_after = pop ? pend_rest : pend_q;
		take       = item_valid && (pend_after == '0);
		idx        = '0;
		for (int i = 0; i < PEND_W; i++) begin
			if (pick[i]) begin
				idx = 3'(i);
			end
		end
	end

	// Result fields for the picked entry
	always_comb begin
		nxt.channel = idx[2];
		unique case (idx[1:0])
			2'(EMIT_CRIT):   nxt.alarm_kind = KIND_CRIT;
			2'(EMIT_LOW):    nxt.alarm_kind = KIND_LOW;
			2'(EMIT_HIGH):   nxt.alarm_kind = KIND_HIGH;
			default:         nxt.alarm_kind = KIND_SENSOR;
		endcase
		if (nxt.alarm_kind == KIND_SENSOR) begin
			nxt.level = '0;
		end else begin
			nxt.level = idx[2] ? lvl_b_q : lvl_a_q;
		end
		nxt.last = (pend_rest == '0);
	end

	// Pending set and levels of the item in the merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (take) begin
			pend_q <= {fire_b, fire_a};
		end else begin
			pend_q <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lvl_a_q <= level_a;
			lvl_b_q <= level_b;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!alarm_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= nxt;
		end
	end

	assign alarm_valid = out_valid_q;
	assign alarm       = out_q;

endmodule

### rtl/level_alarm_hysteresis_ratelimit.sv
`timescale 1ns / 1ps
// An item's first result passes the input stage, merge stage and output register.
// Throughput: one item per cycle when it raises at most one alarm and the output is
// not stalled; else the single output register sends its up to 4 alarms one a cycle.
// Reset: thresholds and interval to their defaults, all alarms armed, time stamps zero;
// no clearing pass, an item can be accepted in the first cycle after reset.
module level_alarm_hysteresis_ratelimit import lahr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  sample_t    sample,
	output logic       alarm_valid,
	input  logic       alarm_stall,
	output alarm_t     alarm,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  reg_index_t cfg_index,
	input  msec_t      cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	sample_t           sample_s1;
	logic              take;
	logic [EMIT_W-1:0] fire_a, fire_b;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_low_level <= RST_CRIT_LOW;
			cfg_q.low_level          <= RST_LOW;
			cfg_q.high_level         <= RST_HIGH;
			cfg_q.hysteresis_band    <= RST_HYSTERESIS;
			cfg_q.min_interval_ms    <= RST_MIN_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CRIT_LOW:     cfg_q.critical_low_level <= cfg_data[9:0];
				REG_LOW:          cfg_q.low_level          <= cfg_data[9:0];
				REG_HIGH:         cfg_q.high_level         <= cfg_data[9:0];
				REG_HYSTERESIS:   cfg_q.hysteresis_band    <= cfg_data[9:0];
				REG_MIN_INTERVAL: cfg_q.min_interval_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage
	assign sample_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// Channel lanes
	lahr_lane u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (take),
		.level     (sample_s1.level_a),
		.sensor_ok (sample_s1.sensor_ok_a),
		.now_ms    (sample_s1.now_ms),
		.cfg       (cfg_q),
		.fire      (fire_a)
	);

	lahr_lane u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (take),
		.level     (sample_s1.level_b),
		.sensor_ok (sample_s1.sensor_ok_b),
		.now_ms    (sample_s1.now_ms),
		.cfg       (cfg_q),
		.fire      (fire_b)
	);

	// Merge and output
	lahr_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.fire_a      (fire_a),
		.fire_b      (fire_b),
		.level_a     (sample_s1.level_a),
		.level_b     (sample_s1.level_b),
		.take        (take),
		.alarm_valid (alarm_valid),
		.alarm_stall (alarm_stall),
		.alarm       (alarm)
	);

endmodule

### rtl/lahr_checker.sv
`timescale 1ns / 1ps
`include "level_alarm_hysteresis_ratelimit_defines.svh"

// Port-level checks on the alarm output
module lahr_checker import lahr_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   alarm_valid,
	input logic   alarm_stall,
	input alarm_t alarm
);

	logic sent;
	assign sent = alarm_valid && !alarm_stall;

	`LAHR_ASSERT_NEXT(a_stall_holds, alarm_valid && alarm_stall, alarm_valid && $stable(alarm), "stalled alarm item changed")
	`LAHR_ASSERT_NOW(a_sensor_level, alarm_valid && (alarm.alarm_kind == KIND_SENSOR), alarm.level == '0, "sensor error with nonzero level")
	`LAHR_ASSERT_NEXT(a_burst_gapless, sent && !alarm.last, alarm_valid, "gap inside one item's alarms")
	`LAHR_ASSERT_NEXT(a_chan_order, sent && !alarm.last && (alarm.channel || (alarm.alarm_kind == KIND_SENSOR)), alarm.channel, "channel one alarm followed by channel zero")

endmodule

bind level_alarm_hysteresis_ratelimit lahr_checker u_lahr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.alarm_valid (alarm_valid),
	.alarm_stall (alarm_stall),
	.alarm       (alarm)
);
